[sv/vvdr_pkg.sv]
package vvdr_pkg;

    // field widths
    localparam int VOLT_W     = 20;
    localparam int DB_W       = 17;
    localparam int DROOP_W    = 17;
    localparam int KVAR_W     = 24;
    localparam int OUT_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // reduced excess times rated kVAR, and one quotient bit per divider stage
    localparam int PROD_W = DROOP_W + KVAR_W;
    localparam int QUO_W  = KVAR_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT     = 3'd0,
        REG_OVER_DB      = 3'd1,
        REG_OVER_DROOP   = 3'd2,
        REG_OVER_RATED   = 3'd3,
        REG_UNDER_DB     = 3'd4,
        REG_UNDER_DROOP  = 3'd5,
        REG_UNDER_RATED  = 3'd6,
        REG_SYMMETRIC    = 3'd7
    } t_cfg_idx;

    // per-request data that rides alongside the divider
    typedef struct packed {
        logic              over;
        logic              active;
        logic              sat;
        logic              zero;
        logic [KVAR_W-1:0] rated;
        logic [KVAR_W-1:0] avail;
    } t_side;

endpackage

[sv/vvdr_in_if.sv]
interface vvdr_in_if import vvdr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] measured_volts;
    logic [KVAR_W-1:0] available_kvar;

    modport source (output valid, output measured_volts, output available_kvar, input ready);
    modport sink   (input valid, input measured_volts, input available_kvar, output ready);
endinterface

[sv/vvdr_out_if.sv]
interface vvdr_out_if import vvdr_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] site_demand_kvar;
    logic                    response_active;
    logic signed [OUT_W-1:0] capped_request_kvar;

    modport source (output valid, output site_demand_kvar, output response_active,
                    output capped_request_kvar, input ready);
    modport sink   (input valid, input site_demand_kvar, input response_active,
                    input capped_request_kvar, output ready);
endinterface

[sv/volt_var_droop_response.sv]
// Volt-var droop response: the result passes through 27 register stages (stage 1,
// stage 2, the divider stages and the output register); the accepting edge loads the first one.
// Throughput one request per cycle while the output is not held; the 24-stage bit-per-stage divider sets the depth.
// The whole pipeline holds while the output register is full and not taken.
// Synchronous active-low reset clears all valid bits and the configuration
// registers (symmetric mode comes up set, all others zero).
module volt_var_droop_response import vvdr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vvdr_in_if.sink               i_req,
    vvdr_out_if.source            o_rsp
);

    // configuration registers
    logic [VOLT_W-1:0]  r_setp;
    logic [DB_W-1:0]    r_over_db;
    logic [DROOP_W-1:0] r_over_droop;
    logic [KVAR_W-1:0]  r_over_rated;
    logic [DB_W-1:0]    r_under_db;
    logic [DROOP_W-1:0] r_under_droop;
    logic [KVAR_W-1:0]  r_under_rated;
    logic               r_sym;

    // pipeline control
    logic en;

    // stage 1 signals
    logic [DB_W-1:0]         u_db;
    logic [DROOP_W-1:0]      u_droop;
    logic [KVAR_W-1:0]       u_rated;
    logic signed [VOLT_W+1:0] meas_s;
    logic signed [VOLT_W+1:0] ref_over;
    logic signed [VOLT_W+1:0] ref_under;
    logic signed [VOLT_W+1:0] diff;
    logic                    over;
    logic [VOLT_W-1:0]       n_excess;
    logic [DROOP_W-1:0]      n_droop;
    logic [KVAR_W-1:0]       n_rated;

    logic               r1_valid;
    logic [VOLT_W-1:0]  r1_excess;
    logic [DROOP_W-1:0] r1_droop;
    t_side              r1_side;

    // stage 2 signals
    t_side              n2_side;
    logic               r2_valid;
    logic [PROD_W-1:0]  r2_prod;
    logic [DROOP_W-1:0] r2_droop;
    t_side              r2_side;

    // divider outputs
    logic               div_valid;
    logic [QUO_W-1:0]   div_quo;
    t_side              div_side;

    // output stage
    logic [KVAR_W-1:0]       mag;
    logic [KVAR_W-1:0]       dmag;
    logic signed [OUT_W-1:0] n_req;
    logic signed [OUT_W-1:0] n_dem;
    logic                    r_o_valid;
    logic signed [OUT_W-1:0] r_o_dem;
    logic signed [OUT_W-1:0] r_o_req;
    logic                    r_o_active;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setp        <= '0;
            r_over_db     <= '0;
            r_over_droop  <= '0;
            r_over_rated  <= '0;
            r_under_db    <= '0;
            r_under_droop <= '0;
            r_under_rated <= '0;
            r_sym         <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_SETPOINT:    r_setp        <= i_cfg_data[VOLT_W-1:0];
                REG_OVER_DB:     r_over_db     <= i_cfg_data[DB_W-1:0];
                REG_OVER_DROOP:  r_over_droop  <= i_cfg_data[DROOP_W-1:0];
                REG_OVER_RATED:  r_over_rated  <= i_cfg_data[KVAR_W-1:0];
                REG_UNDER_DB:    r_under_db    <= i_cfg_data[DB_W-1:0];
                REG_UNDER_DROOP: r_under_droop <= i_cfg_data[DROOP_W-1:0];
                REG_UNDER_RATED: r_under_rated <= i_cfg_data[KVAR_W-1:0];
                REG_SYMMETRIC:   r_sym         <= i_cfg_data[0];
                default:         r_sym         <= r_sym;
            endcase
        end
    end

    // advance everything unless a finished result is stuck at the output
    assign en          = !r_o_valid || o_rsp.ready;
    assign i_req.ready = en;

    // stage 1: pick side, measure distance past the deadband edge
    always_comb begin
        u_db      = r_sym ? r_over_db    : r_under_db;
        u_droop   = r_sym ? r_over_droop : r_under_droop;
        u_rated   = r_sym ? r_over_rated : r_under_rated;
        meas_s    = $signed({2'b00, i_req.measured_volts});
        ref_over  = $signed({2'b00, r_setp}) + $signed({5'b00000, r_over_db});
        ref_under = $signed({2'b00, r_setp}) - $signed({5'b00000, u_db});
        over      = i_req.measured_volts > r_setp;
        if (over) begin
            diff    = meas_s - ref_over;
            n_droop = r_over_droop;
            n_rated = r_over_rated;
        end else begin
            diff    = ref_under - meas_s;
            n_droop = u_droop;
            n_rated = u_rated;
        end
        n_excess = (diff > 0) ? diff[VOLT_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_excess       <= n_excess;
            r1_droop        <= n_droop;
            r1_side.over    <= over;
            r1_side.active  <= n_excess != '0;
            r1_side.sat     <= 1'b0;
            r1_side.zero    <= 1'b0;
            r1_side.rated   <= n_rated;
            r1_side.avail   <= i_req.available_kvar;
        end
    end

    // stage 2: flag saturation and zero droop, form the product
    always_comb begin
        n2_side      = r1_side;
        n2_side.sat  = r1_excess >= VOLT_W'(r1_droop);
        n2_side.zero = r1_droop == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    // excess below the droop fits the droop width, so the product stays narrow
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_prod  <= PROD_W'(r1_excess[DROOP_W-1:0]) * PROD_W'(r1_side.rated);
            r2_droop <= r1_droop;
            r2_side  <= n2_side;
        end
    end

    // divide the product by the droop
    vvdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_valid),
        .i_rem   (r2_prod),
        .i_droop (r2_droop),
        .i_side  (r2_side),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // output stage: cap at rated, limit by available, apply sign
    always_comb begin
        if (div_side.zero) begin
            mag = '0;
        end else if (div_side.sat || (div_quo > div_side.rated)) begin
            mag = div_side.rated;
        end else begin
            mag = div_quo;
        end
        dmag  = (mag < div_side.avail) ? mag : div_side.avail;
        n_req = div_side.over ? -$signed(OUT_W'(mag))  : $signed(OUT_W'(mag));
        n_dem = div_side.over ? -$signed(OUT_W'(dmag)) : $signed(OUT_W'(dmag));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_dem    <= n_dem;
            r_o_req    <= n_req;
            r_o_active <= div_side.active;
        end
    end

    assign o_rsp.valid               = r_o_valid;
    assign o_rsp.site_demand_kvar    = r_o_dem;
    assign o_rsp.response_active     = r_o_active;
    assign o_rsp.capped_request_kvar = r_o_req;

endmodule

[sv/vvdr_div.sv]
// Restoring divider, one quotient bit per pipeline stage, MSB first.
// The dividend must be below divisor * 2^QUO_W.
module vvdr_div import vvdr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [PROD_W-1:0]  i_rem,
    input  logic [DROOP_W-1:0] i_droop,
    input  t_side              i_side,
    output logic               o_valid,
    output logic [QUO_W-1:0]   o_quo,
    output t_side              o_side
);

    logic               r_valid [QUO_W];
    logic [PROD_W-1:0]  r_rem   [QUO_W];
    logic [QUO_W-1:0]   r_quo   [QUO_W];
    logic [DROOP_W-1:0] r_droop [QUO_W];
    t_side              r_side  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic               s_valid;
        logic [PROD_W-1:0]  s_rem;
        logic [QUO_W-1:0]   s_quo;
        logic [DROOP_W-1:0] s_droop;
        t_side              s_side;
        logic [PROD_W-1:0]  s_dvs;
        logic               s_ge;
        logic [PROD_W-1:0]  n_rem;
        logic [QUO_W-1:0]   n_quo;

        // pick up the previous stage
        if (k == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_rem   = i_rem;
            assign s_quo   = '0;
            assign s_droop = i_droop;
            assign s_side  = i_side;
        end else begin : g_next
            assign s_valid = r_valid[k-1];
            assign s_rem   = r_rem[k-1];
            assign s_quo   = r_quo[k-1];
            assign s_droop = r_droop[k-1];
            assign s_side  = r_side[k-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        assign s_dvs = PROD_W'(s_droop) << (QUO_W - 1 - k);
        assign s_ge  = s_rem >= s_dvs;
        assign n_rem = s_ge ? (s_rem - s_dvs) : s_rem;
        assign n_quo = {s_quo[QUO_W-2:0], s_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]   <= n_rem;
                r_quo[k]   <= n_quo;
                r_droop[k] <= s_droop;
                r_side[k]  <= s_side;
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

[verif/volt_var_droop_response_tb.sv]
`timescale 1ns / 100ps

module volt_var_droop_response_tb;
    import vvdr_pkg::*;

    // one voltage reading and the reactive power on hand
    typedef struct {
        logic [VOLT_W-1:0] meas;
        logic [KVAR_W-1:0] avail;
    } t_reading;

    // one predicted response
    typedef struct {
        logic signed [OUT_W-1:0] demand;
        logic                    active;
        logic signed [OUT_W-1:0] request;
    } t_var_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vvdr_in_if  req_if ();
    vvdr_out_if rsp_if ();

    volt_var_droop_response dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source)
    );

    // shadow copy of the settings, at reset values
    logic [VOLT_W-1:0]  cfg_setpoint    = '0;
    logic [DB_W-1:0]    cfg_over_db     = '0;
    logic [DROOP_W-1:0] cfg_over_droop  = '0;
    logic [KVAR_W-1:0]  cfg_over_rated  = '0;
    logic [DB_W-1:0]    cfg_under_db    = '0;
    logic [DROOP_W-1:0] cfg_under_droop = '0;
    logic [KVAR_W-1:0]  cfg_under_rated = '0;
    logic               cfg_sym         = 1'b1;

    t_reading    queued_readings[$];
    t_var_result predicted_responses[$];

    int  mismatches = 0;
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int  tx_wait    = 0;
    int  rx_wait    = 0;
    bit  tx_steady  = 1'b0;
    bit  rx_steady  = 1'b0;

    always #4 i_clk = ~i_clk;

    // droop response for one reading under the current settings
    function automatic t_var_result var_response(logic [VOLT_W-1:0] meas_v,
                                                 logic [KVAR_W-1:0] avail_v);
        longint meas, avail, setp, ref_v, excess, droop, rated, mag, dmag;
        longint o_db, u_db;
        logic   over;
        t_var_result r;
        meas   = meas_v;
        avail  = avail_v;
        setp   = cfg_setpoint;
        o_db   = cfg_over_db;
        u_db   = cfg_sym ? cfg_over_db : cfg_under_db;
        excess = 0;
        mag    = 0;
        over   = meas > setp;
        if (over) begin
            ref_v = setp + o_db;
            if (meas > ref_v)
                excess = meas - ref_v;
            droop = cfg_over_droop;
            rated = cfg_over_rated;
        end else begin
            // reference may go below zero volts; no response then
            ref_v = setp - u_db;
            if (meas < ref_v)
                excess = ref_v - meas;
            droop = cfg_sym ? cfg_over_droop : cfg_under_droop;
            rated = cfg_sym ? cfg_over_rated : cfg_under_rated;
        end
        if (droop != 0)
            mag = (excess * rated) / droop;
        if (mag > rated)
            mag = rated;
        dmag      = (mag < avail) ? mag : avail;
        r.request = OUT_W'(over ? -mag : mag);
        r.demand  = OUT_W'(over ? -dmag : dmag);
        r.active  = (excess != 0);
        return r;
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // record accepted requests and check every result against the oldest prediction
    always @(posedge i_clk) begin
        t_var_result want;
        in_taken  <= i_rst_n && req_if.valid && req_if.ready;
        out_taken <= i_rst_n && rsp_if.valid && rsp_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready)
            predicted_responses.insert(predicted_responses.size(),
                                       var_response(req_if.measured_volts,
                                                    req_if.available_kvar));
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (predicted_responses.size() == 0) begin
                note_failure($sformatf("result with none pending: demand %0d request %0d",
                                       rsp_if.site_demand_kvar, rsp_if.capped_request_kvar));
            end else begin
                want = predicted_responses.pop_front();
                if (rsp_if.site_demand_kvar !== want.demand
                        || rsp_if.response_active !== want.active
                        || rsp_if.capped_request_kvar !== want.request)
                    note_failure($sformatf(
                        "mismatch: demand %0d/%0d active %0b/%0b request %0d/%0d (exp/got)",
                        want.demand, rsp_if.site_demand_kvar,
                        want.active, rsp_if.response_active,
                        want.request, rsp_if.capped_request_kvar));
            end
        end
    end

    // present queued readings, with a random gap after each one
    always @(negedge i_clk) begin
        t_reading rd;
        if (!req_if.valid || in_taken) begin
            if (tx_wait > 0) begin
                req_if.valid <= 1'b0;
                tx_wait--;
            end else if (queued_readings.size() > 0) begin
                rd = queued_readings.pop_front();
                req_if.valid          <= 1'b1;
                req_if.measured_volts <= rd.meas;
                req_if.available_kvar <= rd.avail;
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;
                tx_wait = tx_steady ? 0 : $urandom_range(0, 14);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // stall the result side for a random count after each result
    always @(negedge i_clk) begin
        if (out_taken) begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            rx_wait = rx_steady ? 0 : $urandom_range(0, 14);
        end
        if (rx_wait > 0) begin
            rsp_if.ready <= 1'b0;
            rx_wait--;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_SETPOINT:    cfg_setpoint    = data[VOLT_W-1:0];
            REG_OVER_DB:     cfg_over_db     = data[DB_W-1:0];
            REG_OVER_DROOP:  cfg_over_droop  = data[DROOP_W-1:0];
            REG_OVER_RATED:  cfg_over_rated  = data[KVAR_W-1:0];
            REG_UNDER_DB:    cfg_under_db    = data[DB_W-1:0];
            REG_UNDER_DROOP: cfg_under_droop = data[DROOP_W-1:0];
            REG_UNDER_RATED: cfg_under_rated = data[KVAR_W-1:0];
            default:         cfg_sym         = data[0];
        endcase
    endtask

    task automatic set_config(int unsigned setp, int unsigned o_db,
                              int unsigned o_droop, int unsigned o_rated,
                              int unsigned u_db, int unsigned u_droop,
                              int unsigned u_rated, int unsigned sym);
        write_reg(REG_SETPOINT, CFG_DATA_W'(setp));
        write_reg(REG_OVER_DB, CFG_DATA_W'(o_db));
        write_reg(REG_OVER_DROOP, CFG_DATA_W'(o_droop));
        write_reg(REG_OVER_RATED, CFG_DATA_W'(o_rated));
        write_reg(REG_UNDER_DB, CFG_DATA_W'(u_db));
        write_reg(REG_UNDER_DROOP, CFG_DATA_W'(u_droop));
        write_reg(REG_UNDER_RATED, CFG_DATA_W'(u_rated));
        write_reg(REG_SYMMETRIC, CFG_DATA_W'(sym));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_reading(logic [VOLT_W-1:0] meas, logic [KVAR_W-1:0] avail);
        t_reading rd;
        rd.meas  = meas;
        rd.avail = avail;
        queued_readings.insert(queued_readings.size(), rd);
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        do
            @(negedge i_clk);
        while (queued_readings.size() != 0 || req_if.valid || predicted_responses.size() != 0);
        repeat (40) @(negedge i_clk);
    endtask

    // pick new settings: mostly plausible grid values, sometimes raw bit patterns
    task automatic random_settings();
        int o_droop, u_droop;
        if ($urandom_range(0, 4) == 0) begin
            set_config($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
        end else begin
            o_droop = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5000);
            u_droop = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5000);
            set_config($urandom_range(0, 1000000), $urandom_range(0, 2000), o_droop,
                       $urandom_range(0, 10000000), $urandom_range(0, 2000), u_droop,
                       $urandom_range(0, 10000000), $urandom_range(0, 1));
        end
    endtask

    // readings clustered around the set point so every region gets hit
    task automatic random_phase(int count);
        longint span, off, m, top;
        logic [KVAR_W-1:0] avail;
        random_settings();
        span = ((cfg_over_db > cfg_under_db) ? cfg_over_db : cfg_under_db)
             + 2 * ((cfg_over_droop > cfg_under_droop) ? cfg_over_droop : cfg_under_droop)
             + 16;
        top = (cfg_over_rated > cfg_under_rated) ? cfg_over_rated : cfg_under_rated;
        top = top + top / 8 + 1;
        if (top > 24'hFFFFFF)
            top = 24'hFFFFFF;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                m = $urandom_range(0, 20'hFFFFF);
            end else begin
                off = longint'($urandom_range(0, int'(2 * span))) - span;
                m = longint'(cfg_setpoint) + off;
                if (m < 0)
                    m = 0;
                if (m > 20'hFFFFF)
                    m = 20'hFFFFF;
            end
            if ($urandom_range(0, 2) == 0)
                avail = KVAR_W'($urandom);
            else
                avail = KVAR_W'($urandom_range(0, int'(top)));
            queue_reading(m[VOLT_W-1:0], avail);
        end
        drain();
    endtask

    // stimulus and final verdict
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        req_if.valid         = 1'b0;
        req_if.measured_volts = '0;
        req_if.available_kvar = '0;
        rsp_if.ready         = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // symmetric grid settings: edges of the deadband, caps and power limits
        set_config(2400, 50, 100, 5000, 10, 20, 300, 1);
        queue_reading(2400, 10000);
        queue_reading(2450, 10000);
        queue_reading(2451, 10000);
        queue_reading(2350, 10000);
        queue_reading(2349, 10000);
        queue_reading(2700, 10000);
        queue_reading(0, 10000);
        queue_reading(20'hFFFFF, 24'hFFFFFF);
        queue_reading(2500, 0);
        queue_reading(2520, 1234);
        queue_reading(2420, 3000);
        queue_reading(2300, 3000);
        drain();

        // zero over droop, under deadband reaching below zero volts
        set_config(2400, 50, 0, 5000, 3000, 200, 8000, 0);
        queue_reading(2600, 10000);
        queue_reading(0, 10000);
        queue_reading(2400, 10000);
        drain();

        // widest values with spare upper bits, zero under droop
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   24'hFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFE);
        queue_reading(0, 24'hFFFFFF);
        queue_reading(20'hFFFFF, 0);
        queue_reading(917503, 5);
        drain();

        // unit droop drives the request to the rated cap
        set_config(500000, 0, 1, 24'hFFFFFF, 0, 0, 0, 1);
        queue_reading(500001, 24'hFFFFFF);
        queue_reading(499999, 24'hFFFFFF);
        queue_reading(500001, 100);
        queue_reading(500000, 100);
        drain();

        // everything zero
        set_config(0, 0, 0, 0, 0, 0, 0, 0);
        queue_reading(0, 24'hFFFFFF);
        queue_reading(20'hFFFFF, 5);
        drain();

        for (int p = 0; p < 14; p++)
            random_phase(70);

        if (mismatches == 0 && predicted_responses.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
